// ----- sv/two_link_leg_inverse_kinematics_unit_macros.svh -----
// assertion macros for the leg inverse kinematics port checker
`ifndef TWO_LINK_LEG_INVERSE_KINEMATICS_UNIT_MACROS_SVH
`define TWO_LINK_LEG_INVERSE_KINEMATICS_UNIT_MACROS_SVH

// same-cycle implication, masked while in reset
`define TLIK_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tlik assertion failed");

// next-cycle implication, masked while in reset
`define TLIK_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tlik assertion failed");

// next-cycle implication that also holds through reset
`define TLIK_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("tlik assertion failed");

`endif

// ----- sv/tlik_pkg.sv -----
// shared types, constants and tables of the leg inverse kinematics unit
`timescale 1ns / 1ps
package tlik_pkg;

    localparam int NUM_POINTS  = 64;
    localparam int IDX_W       = 6;
    localparam int CNT_W       = 7;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // cordic datapath
    localparam int CW           = 50;
    localparam int ZW           = 21;
    localparam int CORDIC_ITERS = 17;
    localparam logic signed [ZW-1:0] PI_Q16   = 21'sd205887;
    localparam logic signed [CW-1:0] NORM_LIM  = CW'(64'd1 << 40);
    localparam logic signed [CW-1:0] NORM_LIM8 = CW'(64'd1 << 33);

    // divider and square root step counts
    localparam int DIV_STEPS  = 30;
    localparam int SQRT_STEPS = 31;

    function automatic logic signed [ZW-1:0] atan_entry(input logic [4:0] i);
        logic signed [ZW-1:0] v;
        case (i)
            5'd0:    v = 21'sd51472;
            5'd1:    v = 21'sd30385;
            5'd2:    v = 21'sd16055;
            5'd3:    v = 21'sd8150;
            5'd4:    v = 21'sd4091;
            5'd5:    v = 21'sd2047;
            5'd6:    v = 21'sd1024;
            5'd7:    v = 21'sd512;
            5'd8:    v = 21'sd256;
            5'd9:    v = 21'sd128;
            5'd10:   v = 21'sd64;
            5'd11:   v = 21'sd32;
            5'd12:   v = 21'sd16;
            5'd13:   v = 21'sd8;
            5'd14:   v = 21'sd4;
            5'd15:   v = 21'sd2;
            5'd16:   v = 21'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

    typedef enum logic [1:0] {
        STATUS_OK,
        STATUS_UNREACHABLE,
        STATUS_HIP_RANGE,
        STATUS_KNEE_RANGE
    } status_t;

    typedef enum logic [2:0] {
        REG_UPPER_LINK,
        REG_LOWER_LINK,
        REG_HIP_HEIGHT,
        REG_STAND_HIP_OFFSET,
        REG_HIP_MIN,
        REG_HIP_MAX,
        REG_KNEE_MIN,
        REG_KNEE_MAX
    } cfg_index_t;

    typedef struct packed {
        logic        [14:0] upper_link_length;
        logic        [14:0] lower_link_length;
        logic        [14:0] hip_height;
        logic signed [15:0] stand_hip_offset;
        logic signed [15:0] hip_angle_min;
        logic signed [15:0] hip_angle_max;
        logic signed [15:0] knee_angle_min;
        logic signed [15:0] knee_angle_max;
    } cfg_t;

    typedef struct packed {
        logic signed [15:0] foot_x;
        logic signed [15:0] foot_y;
        logic [IDX_W-1:0]   index;
        logic               last;
        logic [IDX_W-1:0]   nearest;
    } point_entry_t;

    typedef struct packed {
        logic signed [15:0] hip_angle;
        logic signed [15:0] knee_angle;
        logic [IDX_W-1:0]   point_index;
        status_t            status;
        logic               last;
    } result_t;

    typedef struct packed {
        logic                 start;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] x;
    } cordic_req_t;

    typedef struct packed {
        logic               done;
        logic signed [15:0] angle;
    } cordic_rsp_t;

    typedef enum logic [1:0] {
        CD_IDLE,
        CD_NORM,
        CD_ITER,
        CD_DONE
    } cordic_state_t;

    typedef enum logic [4:0] {
        BK_IDLE,
        BK_SQX,
        BK_SQY,
        BK_L1SQ,
        BK_L2SQ,
        BK_LPROD,
        BK_CHECK,
        BK_DIV,
        BK_DQSQ,
        BK_SQINIT,
        BK_SQRT,
        BK_KNEE,
        BK_KNEE_WAIT,
        BK_AY,
        BK_AX,
        BK_ALPHA,
        BK_ALPHA_WAIT,
        BK_FOOT,
        BK_FOOT_WAIT,
        BK_STORE,
        BK_STAND_RD,
        BK_STAND_LD,
        BK_EMIT_RD,
        BK_EMIT_LD,
        BK_EMIT_OUT
    } back_state_t;

endpackage

// ----- sv/two_link_leg_inverse_kinematics_unit.sv -----
// top level of the two-link leg inverse kinematics unit
`timescale 1ns / 1ps
// usage
//   s_ channel: one foot point per transfer, a path of NUM_POINTS points makes a run
//   m_ channel: after the last point of a run, NUM_POINTS results in point order,
//     tlast on the final one, status code in tuser
//   cfg port: write registers only while the unit is idle, no read-back
// timing
//   the front takes a point in the cycle it arrives unless its stage and the
//   four-deep queue are full; points flow on while the back is busy
//   the back solves one point at a time: eight multiplier steps, a 30-step divider
//   and a 31-step square root, plus three runs of the shared cordic (a zero vector
//   skips the iterations); an unreachable point skips the divider, root and cordic
//   emission then reads each result from the store and holds it until m_tready
//   before reading the next one
// reset
//   aresetn low clears the run state, queue, sequencers and output valid and holds
//   s_tready low; registers return to their defaults, the angle stores keep contents
// back-pressure
//   a result waits in the output register while m_tready is low; the front keeps
//   taking points until the queue fills, then drops s_tready
module two_link_leg_inverse_kinematics_unit import tlik_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // foot_x [15:0], foot_y [31:16]
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // hip_angle [15:0], knee_angle [31:16],
                                   // point_index [37:32], zero pad [39:38]
    output logic [1:0]  m_tuser,   // status [1:0]
    output logic        m_tlast,   // last
    // configuration writes
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_wr_index,
    input  logic [15:0] cfg_wr_data
);

    cfg_t         cfg_reg, cfg_next;
    logic         push, pop, q_full, q_empty;
    point_entry_t push_data, pop_data;
    result_t      result;

    // configuration register bank
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_wr_index))
                REG_UPPER_LINK:       cfg_next.upper_link_length = cfg_wr_data[14:0];
                REG_LOWER_LINK:       cfg_next.lower_link_length = cfg_wr_data[14:0];
                REG_HIP_HEIGHT:       cfg_next.hip_height        = cfg_wr_data[14:0];
                REG_STAND_HIP_OFFSET: cfg_next.stand_hip_offset  = cfg_wr_data;
                REG_HIP_MIN:          cfg_next.hip_angle_min     = cfg_wr_data;
                REG_HIP_MAX:          cfg_next.hip_angle_max     = cfg_wr_data;
                REG_KNEE_MIN:         cfg_next.knee_angle_min    = cfg_wr_data;
                REG_KNEE_MAX:         cfg_next.knee_angle_max    = cfg_wr_data;
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.upper_link_length <= 15'd1638;
            cfg_reg.lower_link_length <= 15'd1638;
            cfg_reg.hip_height        <= 15'd2458;
            cfg_reg.stand_hip_offset  <= 16'sd2621;
            cfg_reg.hip_angle_min     <= 16'sh8000;
            cfg_reg.hip_angle_max     <= 16'sh7FFF;
            cfg_reg.knee_angle_min    <= 16'sh8000;
            cfg_reg.knee_angle_max    <= 16'sh7FFF;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // front: numbering and nearest stand point
    tlik_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_tvalid),
        .s_ready       (s_tready),
        .foot_x        (s_tdata[15:0]),
        .foot_y        (s_tdata[31:16]),
        .hip_height    (cfg_reg.hip_height),
        .queue_full    (q_full),
        .push          (push),
        .push_data     (push_data)
    );

    // decoupling queue
    tlik_fifo u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (q_empty)
    );

    // back: solver, angle stores and emission
    tlik_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .queue_empty (q_empty),
        .queue_data  (pop_data),
        .pop         (pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_data    (result)
    );

    assign m_tdata = {2'b00, result.point_index, result.knee_angle, result.hip_angle};
    assign m_tuser = result.status;
    assign m_tlast = result.last;

endmodule

// ----- sv/tlik_fifo.sv -----
// short queue of classified points between front and back
`timescale 1ns / 1ps
module tlik_fifo import tlik_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  point_entry_t push_data,
    output logic         full,
    input  logic         pop,
    output point_entry_t pop_data,
    output logic         empty
);

    point_entry_t      mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;

    assign full     = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ----- sv/tlik_cordic.sv -----
// iterative vectoring cordic giving atan2 in q3.12
`timescale 1ns / 1ps
module tlik_cordic import tlik_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  cordic_req_t req,
    output cordic_rsp_t rsp
);

    cordic_state_t        state_reg, state_next;
    logic signed [CW-1:0] x_reg, x_next;
    logic signed [CW-1:0] y_reg, y_next;
    logic signed [ZW-1:0] z_reg, z_next;
    logic [4:0]           iter_reg, iter_next;

    logic signed [CW-1:0] shx, shy;
    logic signed [ZW:0]   z_ext, r_pos, r_neg;
    logic                 fits1, fits8;

    assign shx   = x_reg >>> iter_reg;
    assign shy   = y_reg >>> iter_reg;
    assign fits1 = (x_reg < NORM_LIM) && (y_reg < NORM_LIM) && (y_reg > -NORM_LIM);
    assign fits8 = (x_reg < NORM_LIM8) && (y_reg < NORM_LIM8) && (y_reg > -NORM_LIM8);

    // round half away from zero, q16 to q12
    assign z_ext = {z_reg[ZW-1], z_reg};
    assign r_pos = (z_ext + (ZW+1)'(8)) >>> 4;
    assign r_neg = -(((-z_ext) + (ZW+1)'(8)) >>> 4);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CD_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        iter_reg <= iter_next;
    end

    always_comb begin
        state_next = state_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        iter_next  = iter_reg;
        rsp.done   = 1'b0;
        rsp.angle  = z_reg[ZW-1] ? r_neg[15:0] : r_pos[15:0];
        unique case (state_reg)
            CD_IDLE: begin
                if (req.start) begin
                    x_next    = req.x;
                    y_next    = req.y;
                    z_next    = '0;
                    iter_next = '0;
                    if (req.x == '0 && req.y == '0) begin
                        state_next = CD_DONE;
                    end else begin
                        if (req.x[CW-1]) begin
                            // left half plane: fold over by pi
                            z_next = req.y[CW-1] ? -PI_Q16 : PI_Q16;
                            x_next = -req.x;
                            y_next = -req.y;
                        end
                        state_next = CD_NORM;
                    end
                end
            end
            CD_NORM: begin
                if (fits8) begin
                    x_next = x_reg <<< 8;
                    y_next = y_reg <<< 8;
                end else if (fits1) begin
                    x_next = x_reg <<< 1;
                    y_next = y_reg <<< 1;
                end else begin
                    state_next = CD_ITER;
                end
            end
            CD_ITER: begin
                if (!y_reg[CW-1]) begin
                    x_next = x_reg + shy;
                    y_next = y_reg - shx;
                    z_next = z_reg + atan_entry(iter_reg);
                end else begin
                    x_next = x_reg - shy;
                    y_next = y_reg + shx;
                    z_next = z_reg - atan_entry(iter_reg);
                end
                iter_next = iter_reg + 1'b1;
                if (iter_reg == 5'(CORDIC_ITERS - 1)) begin
                    state_next = CD_DONE;
                end
            end
            CD_DONE: begin
                rsp.done   = 1'b1;
                state_next = CD_IDLE;
            end
            default: state_next = CD_IDLE;
        endcase
    end

endmodule

// ----- sv/tlik_front.sv -----
// front end: takes points, numbers them and tracks the point nearest the stand pose
`timescale 1ns / 1ps
module tlik_front import tlik_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] foot_x,
    input  logic signed [15:0] foot_y,
    input  logic        [14:0] hip_height,
    input  logic               queue_full,
    output logic               push,
    output point_entry_t       push_data
);

    logic               s1_valid_reg, s1_valid_next;
    logic signed [15:0] x_reg, y_reg;
    logic [30:0]        xsq_reg;
    logic [32:0]        dysq_reg;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]   near_idx_reg, near_idx_next;
    logic [31:0]        near_dist_reg, near_dist_next;

    logic signed [17:0] dy;
    logic signed [31:0] xsq_full;
    logic signed [35:0] dysq_full;
    logic [33:0]        dist_sum;
    logic [31:0]        dist_sat;
    logic               closer, is_last;
    logic [IDX_W-1:0]   idx;

    assign dy        = $signed({{2{foot_y[15]}}, foot_y}) + $signed({3'b000, hip_height});
    assign xsq_full  = foot_x * foot_x;
    assign dysq_full = dy * dy;

    // no transfer is taken while in reset
    assign s_ready = aresetn && (!s1_valid_reg || !queue_full);
    assign push    = s1_valid_reg && !queue_full;

    assign dist_sum = {3'b000, xsq_reg} + {1'b0, dysq_reg};
    assign dist_sat = (dist_sum[33:32] != 2'b00) ? 32'hFFFF_FFFF : dist_sum[31:0];
    assign closer   = dist_sat < near_dist_reg;
    assign idx      = count_reg[IDX_W-1:0];
    assign is_last  = (count_reg == CNT_W'(NUM_POINTS - 1));

    always_comb begin
        push_data.foot_x  = x_reg;
        push_data.foot_y  = y_reg;
        push_data.index   = idx;
        push_data.last    = is_last;
        push_data.nearest = closer ? idx : near_idx_reg;
    end

    always_comb begin
        s1_valid_next  = s1_valid_reg;
        count_next     = count_reg;
        near_idx_next  = near_idx_reg;
        near_dist_next = near_dist_reg;
        if (push) begin
            s1_valid_next = 1'b0;
            if (is_last) begin
                count_next     = '0;
                near_idx_next  = '0;
                near_dist_next = '1;
            end else begin
                count_next = count_reg + 1'b1;
                if (closer) begin
                    near_idx_next  = idx;
                    near_dist_next = dist_sat;
                end
            end
        end
        if (s_valid && s_ready) begin
            s1_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            count_reg     <= '0;
            near_idx_reg  <= '0;
            near_dist_reg <= '1;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            count_reg     <= count_next;
            near_idx_reg  <= near_idx_next;
            near_dist_reg <= near_dist_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            x_reg    <= foot_x;
            y_reg    <= foot_y;
            xsq_reg  <= xsq_full[30:0];
            dysq_reg <= dysq_full[32:0];
        end
    end

endmodule

// ----- sv/tlik_back.sv -----
// back end: solves each point, stores the raw angles and emits the run
`timescale 1ns / 1ps
module tlik_back import tlik_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  cfg_t         cfg,
    input  logic         queue_empty,
    input  point_entry_t queue_data,
    output logic         pop,
    output logic         out_valid,
    input  logic         out_ready,
    output result_t      out_data
);

    back_state_t        state_reg, state_next;
    point_entry_t       entry_reg, entry_next;
    logic signed [63:0] prod_reg;
    logic signed [33:0] acc_reg, acc_next;
    logic [31:0]        den_reg, den_next;
    logic [32:0]        rem_reg, rem_next;
    logic [30:0]        quo_reg, quo_next;
    logic               neg_reg, neg_next;
    logic [4:0]         step_reg, step_next;
    logic [60:0]        sq_val_reg, sq_val_next;
    logic [61:0]        sq_res_reg, sq_res_next;
    logic [60:0]        sq_bit_reg, sq_bit_next;
    logic signed [31:0] dq_reg, dq_next;
    logic signed [CW-1:0] ay_reg, ay_next;
    logic signed [15:0] knee_raw_reg, knee_raw_next;
    logic signed [15:0] alpha_reg, alpha_next;
    logic signed [15:0] hip_raw_reg, hip_raw_next;
    logic signed [15:0] stand_reg, stand_next;
    logic               flag_reg, flag_next;
    logic [IDX_W-1:0]   emit_idx_reg, emit_idx_next;
    logic               out_valid_reg, out_valid_next;
    result_t            out_reg, out_next;

    // raw angle stores
    logic signed [15:0] hip_mem [NUM_POINTS];
    logic signed [15:0] knee_mem [NUM_POINTS];
    logic signed [15:0] rd_hip_reg, rd_knee_reg;
    logic               wr_en, rd_en;
    logic [IDX_W-1:0]   rd_addr;

    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] product;
    logic [32:0]        mag;
    logic [31:0]        den_w;
    logic [32:0]        rem2;
    logic               rem_ge;
    logic signed [31:0] dq_w;
    logic [61:0]        sq_sum;
    logic signed [31:0] s_w;
    logic signed [CW-1:0] cx_w;
    logic signed [16:0] hip_diff;
    logic signed [17:0] hip_w;
    logic signed [16:0] knee_w;
    cordic_req_t        creq;
    cordic_rsp_t        crsp;

    tlik_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (creq),
        .rsp     (crsp)
    );

    assign product   = mul_a * mul_b;
    assign mag       = acc_reg[33] ? 33'(-acc_reg) : acc_reg[32:0];
    assign den_w     = {prod_reg[30:0], 1'b0};
    assign rem2      = {rem_reg[31:0], 1'b0};
    assign rem_ge    = rem2 >= {1'b0, den_reg};
    assign dq_w      = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});
    assign sq_sum    = sq_res_reg + {1'b0, sq_bit_reg};
    assign s_w       = $signed({1'b0, sq_res_reg[30:0]});
    assign cx_w      = $signed(CW'({cfg.upper_link_length, 30'd0})) + prod_reg[CW-1:0];
    assign hip_diff  = 17'(crsp.angle) - 17'(alpha_reg);
    assign hip_w     = 18'(stand_reg) + 18'(cfg.stand_hip_offset) - 18'(rd_hip_reg);
    assign knee_w    = -17'(rd_knee_reg);

    assign pop       = (state_reg == BK_IDLE) && !queue_empty;
    assign wr_en     = (state_reg == BK_STORE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            hip_mem[entry_reg.index]  <= hip_raw_reg;
            knee_mem[entry_reg.index] <= knee_raw_reg;
        end
        if (rd_en) begin
            rd_hip_reg  <= hip_mem[rd_addr];
            rd_knee_reg <= knee_mem[rd_addr];
        end
    end

    // shared multiplier operands
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            BK_SQX: begin
                mul_a = 32'(entry_reg.foot_x);
                mul_b = 32'(entry_reg.foot_x);
            end
            BK_SQY: begin
                mul_a = 32'(entry_reg.foot_y);
                mul_b = 32'(entry_reg.foot_y);
            end
            BK_L1SQ: begin
                mul_a = $signed({17'd0, cfg.upper_link_length});
                mul_b = $signed({17'd0, cfg.upper_link_length});
            end
            BK_L2SQ: begin
                mul_a = $signed({17'd0, cfg.lower_link_length});
                mul_b = $signed({17'd0, cfg.lower_link_length});
            end
            BK_LPROD: begin
                mul_a = $signed({17'd0, cfg.upper_link_length});
                mul_b = $signed({17'd0, cfg.lower_link_length});
            end
            BK_DQSQ: begin
                mul_a = dq_w;
                mul_b = dq_w;
            end
            BK_AY: begin
                mul_a = $signed({17'd0, cfg.lower_link_length});
                mul_b = s_w;
            end
            BK_AX: begin
                mul_a = $signed({17'd0, cfg.lower_link_length});
                mul_b = dq_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_IDLE;
            flag_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            flag_reg      <= flag_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg    <= entry_next;
        prod_reg     <= product;
        acc_reg      <= acc_next;
        den_reg      <= den_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        neg_reg      <= neg_next;
        step_reg     <= step_next;
        sq_val_reg   <= sq_val_next;
        sq_res_reg   <= sq_res_next;
        sq_bit_reg   <= sq_bit_next;
        dq_reg       <= dq_next;
        ay_reg       <= ay_next;
        knee_raw_reg <= knee_raw_next;
        alpha_reg    <= alpha_next;
        hip_raw_reg  <= hip_raw_next;
        stand_reg    <= stand_next;
        emit_idx_reg <= emit_idx_next;
        out_reg      <= out_next;
    end

    always_comb begin
        state_next     = state_reg;
        entry_next     = entry_reg;
        acc_next       = acc_reg;
        den_next       = den_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        neg_next       = neg_reg;
        step_next      = step_reg;
        sq_val_next    = sq_val_reg;
        sq_res_next    = sq_res_reg;
        sq_bit_next    = sq_bit_reg;
        dq_next        = dq_reg;
        ay_next        = ay_reg;
        knee_raw_next  = knee_raw_reg;
        alpha_next     = alpha_reg;
        hip_raw_next   = hip_raw_reg;
        stand_next     = stand_reg;
        flag_next      = flag_reg;
        emit_idx_next  = emit_idx_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        rd_en          = 1'b0;
        rd_addr        = emit_idx_reg;
        creq.start     = 1'b0;
        creq.y         = $signed(CW'(entry_reg.foot_y));
        creq.x         = $signed(CW'(entry_reg.foot_x));
        unique case (state_reg)
            BK_IDLE: begin
                if (!queue_empty) begin
                    entry_next = queue_data;
                    state_next = BK_SQX;
                end
            end
            BK_SQX:   state_next = BK_SQY;
            BK_SQY: begin
                acc_next   = prod_reg[33:0];
                state_next = BK_L1SQ;
            end
            BK_L1SQ: begin
                acc_next   = acc_reg + prod_reg[33:0];
                state_next = BK_L2SQ;
            end
            BK_L2SQ: begin
                acc_next   = acc_reg - prod_reg[33:0];
                state_next = BK_LPROD;
            end
            BK_LPROD: begin
                acc_next   = acc_reg - prod_reg[33:0];
                state_next = BK_CHECK;
            end
            BK_CHECK: begin
                if (den_w == '0 || mag > {1'b0, den_w}) begin
                    // unreachable point or zero link
                    flag_next     = 1'b1;
                    hip_raw_next  = '0;
                    knee_raw_next = '0;
                    state_next    = BK_STORE;
                end else begin
                    den_next   = den_w;
                    neg_next   = acc_reg[33];
                    rem_next   = (mag >= {1'b0, den_w}) ? mag - {1'b0, den_w} : mag;
                    quo_next   = {30'd0, mag >= {1'b0, den_w}};
                    step_next  = '0;
                    state_next = BK_DIV;
                end
            end
            BK_DIV: begin
                rem_next  = rem_ge ? rem2 - {1'b0, den_reg} : rem2;
                quo_next  = {quo_reg[29:0], rem_ge};
                step_next = step_reg + 1'b1;
                if (step_reg == 5'(DIV_STEPS - 1)) begin
                    state_next = BK_DQSQ;
                end
            end
            BK_DQSQ: begin
                dq_next    = dq_w;
                state_next = BK_SQINIT;
            end
            BK_SQINIT: begin
                sq_val_next = (61'd1 << 60) - prod_reg[60:0];
                sq_res_next = '0;
                sq_bit_next = 61'd1 << 60;
                step_next   = '0;
                state_next  = BK_SQRT;
            end
            BK_SQRT: begin
                if ({1'b0, sq_val_reg} >= sq_sum) begin
                    sq_val_next = sq_val_reg - sq_sum[60:0];
                    sq_res_next = (sq_res_reg >> 1) + {1'b0, sq_bit_reg};
                end else begin
                    sq_res_next = sq_res_reg >> 1;
                end
                sq_bit_next = sq_bit_reg >> 2;
                step_next   = step_reg + 1'b1;
                if (step_reg == 5'(SQRT_STEPS - 1)) begin
                    state_next = BK_KNEE;
                end
            end
            BK_KNEE: begin
                creq.start = 1'b1;
                creq.y     = $signed(CW'(s_w));
                creq.x     = $signed(CW'(dq_reg));
                state_next = BK_KNEE_WAIT;
            end
            BK_KNEE_WAIT: begin
                if (crsp.done) begin
                    knee_raw_next = crsp.angle;
                    state_next    = BK_AY;
                end
            end
            BK_AY:    state_next = BK_AX;
            BK_AX: begin
                ay_next    = prod_reg[CW-1:0];
                state_next = BK_ALPHA;
            end
            BK_ALPHA: begin
                creq.start = 1'b1;
                creq.y     = ay_reg;
                creq.x     = cx_w;
                state_next = BK_ALPHA_WAIT;
            end
            BK_ALPHA_WAIT: begin
                if (crsp.done) begin
                    alpha_next = crsp.angle;
                    state_next = BK_FOOT;
                end
            end
            BK_FOOT: begin
                creq.start = 1'b1;
                state_next = BK_FOOT_WAIT;
            end
            BK_FOOT_WAIT: begin
                if (crsp.done) begin
                    hip_raw_next = hip_diff[15:0];
                    state_next   = BK_STORE;
                end
            end
            BK_STORE: begin
                state_next = entry_reg.last ? BK_STAND_RD : BK_IDLE;
            end
            BK_STAND_RD: begin
                rd_en      = 1'b1;
                rd_addr    = entry_reg.nearest;
                state_next = BK_STAND_LD;
            end
            BK_STAND_LD: begin
                stand_next    = rd_hip_reg;
                emit_idx_next = '0;
                state_next    = BK_EMIT_RD;
            end
            BK_EMIT_RD: begin
                rd_en      = 1'b1;
                state_next = BK_EMIT_LD;
            end
            BK_EMIT_LD: begin
                out_next.point_index = emit_idx_reg;
                out_next.last        = (emit_idx_reg == IDX_W'(NUM_POINTS - 1));
                out_next.knee_angle  = knee_w[15:0];
                if (hip_w > 18'sd32767) begin
                    out_next.hip_angle = 16'sh7FFF;
                end else if (hip_w < -18'sd32768) begin
                    out_next.hip_angle = 16'sh8000;
                end else begin
                    out_next.hip_angle = hip_w[15:0];
                end
                if (flag_reg) begin
                    out_next.status     = STATUS_UNREACHABLE;
                    out_next.hip_angle  = '0;
                    out_next.knee_angle = '0;
                end else if (hip_w < 18'(cfg.hip_angle_min) || hip_w > 18'(cfg.hip_angle_max)) begin
                    out_next.status = STATUS_HIP_RANGE;
                end else if (knee_w < 17'(cfg.knee_angle_min)
                             || knee_w > 17'(cfg.knee_angle_max)) begin
                    out_next.status = STATUS_KNEE_RANGE;
                end else begin
                    out_next.status = STATUS_OK;
                end
                out_valid_next = 1'b1;
                state_next     = BK_EMIT_OUT;
            end
            BK_EMIT_OUT: begin
                if (out_ready) begin
                    out_valid_next = 1'b0;
                    if (emit_idx_reg == IDX_W'(NUM_POINTS - 1)) begin
                        flag_next  = 1'b0;
                        state_next = BK_IDLE;
                    end else begin
                        emit_idx_next = emit_idx_reg + 1'b1;
                        state_next    = BK_EMIT_RD;
                    end
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

endmodule

// ----- sv/tlik_checker.sv -----
// port-level checker for the leg inverse kinematics unit, bound to the top level
`timescale 1ns / 1ps
`include "two_link_leg_inverse_kinematics_unit_macros.svh"
module tlik_checker import tlik_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    `TLIK_ASSERT_NEXT(out_held, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)
    `TLIK_ASSERT_NEXT(out_stable, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
    `TLIK_ASSERT_IMPL(unreach_zero, aclk, aresetn, m_tvalid && (m_tuser == STATUS_UNREACHABLE), m_tdata[31:0] == 32'd0)
    `TLIK_ASSERT_IMPL(last_index, aclk, aresetn, m_tvalid && m_tlast, m_tdata[37:32] == IDX_W'(NUM_POINTS - 1))
    `TLIK_ASSERT_NEXT_ALWAYS(reset_quiet, aclk, !aresetn, !m_tvalid)

endmodule

bind two_link_leg_inverse_kinematics_unit tlik_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ----- bench/tlik_scoreboard.sv -----
// checker for the leg inverse kinematics unit: watches both channels, predicts and compares
`timescale 1ns / 1ps
module tlik_scoreboard import tlik_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,
    input  logic [1:0]  m_tuser,
    input  logic        m_tlast,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_wr_index,
    input  logic [15:0] cfg_wr_data,
    output int          fail_count,
    output int          angles_pending
);

    localparam longint ATAN_Q16 [17] = '{51472, 30385, 16055, 8150, 4091, 2047, 1024, 512,
                                         256, 128, 64, 32, 16, 8, 4, 2, 1};

    cfg_t               regs;
    logic signed [15:0] hip_raw_mem [NUM_POINTS];
    logic signed [15:0] knee_raw_mem [NUM_POINTS];
    int                 pts_seen;
    int                 near_idx;
    longint unsigned    near_dist;
    bit                 any_unreachable;
    result_t            angle_queue [$];

    function automatic longint half_away(longint v);
        return (v >= 0) ? ((v + 8) >>> 4) : -(((-v) + 8) >>> 4);
    endfunction

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned res, b;
        res = 0;
        b   = 64'h4000_0000_0000_0000;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v   = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic longint vector_angle(longint y, longint x);
        longint z, nx, ny, lim;
        z   = 0;
        lim = 64'sd1 <<< 40;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            z = (y >= 0) ? 205887 : -205887;
            x = -x;
            y = -y;
        end
        while (x < lim && y < lim && y > -lim) begin
            x = x * 2;
            y = y * 2;
        end
        for (int i = 0; i < 17; i++) begin
            if (y >= 0) begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z  = z + ATAN_Q16[i];
            end else begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z  = z - ATAN_Q16[i];
            end
            x = nx;
            y = ny;
        end
        return half_away(z);
    endfunction

    // solve one foot point, and emit the whole path once the last point is in
    task automatic solve_point(logic [31:0] data);
        longint x, y, l1, l2, num, den, dq, s, hip_raw, knee_raw, dy, hip, knee, stand;
        longint unsigned mag, dsq;
        int idx;
        result_t r;
        x   = longint'($signed(data[15:0]));
        y   = longint'($signed(data[31:16]));
        l1  = longint'(regs.upper_link_length);
        l2  = longint'(regs.lower_link_length);
        idx = pts_seen % NUM_POINTS;
        num = x * x + y * y - l1 * l1 - l2 * l2;
        den = 2 * l1 * l2;
        mag = (num < 0) ? -num : num;
        hip_raw  = 0;
        knee_raw = 0;
        if (den == 0 || mag > longint'(den)) begin
            any_unreachable = 1'b1;
        end else begin
            dq = longint'((mag << 30) / longint'(den));
            if (num < 0) dq = -dq;
            s = longint'(root_floor((64'd1 << 60) - longint'(dq * dq)));
            knee_raw = vector_angle(s, dq);
            hip_raw  = vector_angle(y, x) - vector_angle(l2 * s, l1 * (64'sd1 <<< 30) + l2 * dq);
        end
        hip_raw_mem[idx]  = hip_raw[15:0];
        knee_raw_mem[idx] = knee_raw[15:0];

        dy  = y + longint'(regs.hip_height);
        dsq = x * x + dy * dy;
        if (dsq > 64'hFFFF_FFFF) dsq = 64'hFFFF_FFFF;
        if (dsq < near_dist) begin
            near_dist = dsq;
            near_idx  = idx;
        end

        pts_seen++;
        if (pts_seen < NUM_POINTS) return;

        stand = longint'(hip_raw_mem[near_idx]);
        for (int i = 0; i < NUM_POINTS; i++) begin
            hip  = -longint'(hip_raw_mem[i]) + stand + longint'(regs.stand_hip_offset);
            knee = -longint'(knee_raw_mem[i]);
            r.status = STATUS_OK;
            if (any_unreachable) begin
                r.status = STATUS_UNREACHABLE;
                hip  = 0;
                knee = 0;
            end else if (hip < regs.hip_angle_min || hip > regs.hip_angle_max) begin
                r.status = STATUS_HIP_RANGE;
            end else if (knee < regs.knee_angle_min || knee > regs.knee_angle_max) begin
                r.status = STATUS_KNEE_RANGE;
            end
            if (hip > 32767) hip = 32767;
            if (hip < -32768) hip = -32768;
            r.hip_angle   = hip[15:0];
            r.knee_angle  = knee[15:0];
            r.point_index = i[IDX_W-1:0];
            r.last        = (i == NUM_POINTS - 1);
            angle_queue.push_back(r);
        end
        pts_seen        = 0;
        near_idx        = 0;
        near_dist       = 64'hFFFF_FFFF;
        any_unreachable = 1'b0;
    endtask

    task automatic compare_result();
        result_t want;
        if (angle_queue.size() == 0) begin
            $display("%0t: unexpected result transfer, actual %h", $time, m_tdata);
            fail_count++;
            return;
        end
        want = angle_queue.pop_front();
        if (m_tdata[15:0] !== want.hip_angle) begin
            $display("%0t: hip_angle expected %0d actual %0d", $time,
                     want.hip_angle, $signed(m_tdata[15:0]));
            fail_count++;
        end
        if (m_tdata[31:16] !== want.knee_angle) begin
            $display("%0t: knee_angle expected %0d actual %0d", $time,
                     want.knee_angle, $signed(m_tdata[31:16]));
            fail_count++;
        end
        if (m_tdata[37:32] !== want.point_index) begin
            $display("%0t: point_index expected %0d actual %0d", $time,
                     want.point_index, m_tdata[37:32]);
            fail_count++;
        end
        if (m_tuser !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, m_tuser);
            fail_count++;
        end
        if (m_tlast !== want.last) begin
            $display("%0t: last expected %0d actual %0d", $time, want.last, m_tlast);
            fail_count++;
        end
    endtask

    initial fail_count = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            regs.upper_link_length = 15'd1638;
            regs.lower_link_length = 15'd1638;
            regs.hip_height        = 15'd2458;
            regs.stand_hip_offset  = 16'sd2621;
            regs.hip_angle_min     = -16'sd32768;
            regs.hip_angle_max     = 16'sd32767;
            regs.knee_angle_min    = -16'sd32768;
            regs.knee_angle_max    = 16'sd32767;
            pts_seen        = 0;
            near_idx        = 0;
            near_dist       = 64'hFFFF_FFFF;
            any_unreachable = 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index_t'(cfg_wr_index))
                    REG_UPPER_LINK:       regs.upper_link_length = cfg_wr_data[14:0];
                    REG_LOWER_LINK:       regs.lower_link_length = cfg_wr_data[14:0];
                    REG_HIP_HEIGHT:       regs.hip_height        = cfg_wr_data[14:0];
                    REG_STAND_HIP_OFFSET: regs.stand_hip_offset  = cfg_wr_data;
                    REG_HIP_MIN:          regs.hip_angle_min     = cfg_wr_data;
                    REG_HIP_MAX:          regs.hip_angle_max     = cfg_wr_data;
                    REG_KNEE_MIN:         regs.knee_angle_min    = cfg_wr_data;
                    REG_KNEE_MAX:         regs.knee_angle_max    = cfg_wr_data;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) compare_result();
            if (s_tvalid && s_tready) solve_point(s_tdata);
        end
        angles_pending = angle_queue.size();
    end

endmodule

// ----- bench/tb_two_link_leg_inverse_kinematics_unit.sv -----
// testbench top for the leg inverse kinematics unit: stimulus, configuration and verdict
`timescale 1ns / 1ps
module tb_two_link_leg_inverse_kinematics_unit;
    import tlik_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_wr_index = '0;
    logic [15:0] cfg_wr_data = '0;

    int          fail_count;
    int          angles_pending;
    bit          calm = 1'b0;    // set for the stretch with no idling on either side

    two_link_leg_inverse_kinematics_unit uut (
        .aclk, .aresetn,
        .s_tvalid, .s_tready, .s_tdata,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast,
        .cfg_wr_en, .cfg_wr_index, .cfg_wr_data
    );

    tlik_scoreboard checker_i (
        .aclk, .aresetn,
        .s_tvalid, .s_tready, .s_tdata,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast,
        .cfg_wr_en, .cfg_wr_index, .cfg_wr_data,
        .fail_count, .angles_pending
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // result side stalls in about a quarter of cycles, never while calm
    always @(posedge aclk) begin
        m_tready <= calm || ($urandom_range(0, 99) >= 26);
    end

    // one register write per cycle; caller stands on a rising edge
    task automatic write_reg(cfg_index_t idx, logic [15:0] value);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= value;
        @(posedge aclk);
    endtask

    task automatic set_regs(int l1, int l2, int gh, int offs,
                            int hmin, int hmax, int kmin, int kmax);
        write_reg(REG_UPPER_LINK, 16'(l1));
        write_reg(REG_LOWER_LINK, 16'(l2));
        write_reg(REG_HIP_HEIGHT, 16'(gh));
        write_reg(REG_STAND_HIP_OFFSET, 16'(offs));
        write_reg(REG_HIP_MIN, 16'(hmin));
        write_reg(REG_HIP_MAX, 16'(hmax));
        write_reg(REG_KNEE_MIN, 16'(kmin));
        write_reg(REG_KNEE_MAX, 16'(kmax));
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // one foot point transfer, with random idle cycles ahead of it
    task automatic send_point(int x, int y);
        while (!calm && $urandom_range(0, 99) < 26) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {16'(y), 16'(x)};
        do @(posedge aclk); while (!s_tready);
    endtask

    // a path that stays inside the reach of two equal links of length len
    task automatic send_reachable_path(int len);
        int half;
        half = (2 * len * 7) / 10;
        if (half > 32767) half = 32767;
        for (int i = 0; i < NUM_POINTS; i++)
            send_point($urandom_range(0, 2 * half) - half, $urandom_range(0, 2 * half) - half);
    endtask

    task automatic send_random_path(int from);
        for (int i = from; i < NUM_POINTS; i++)
            send_point(int'($signed(16'($urandom))), int'($signed(16'($urandom))));
    endtask

    // let the whole path drain before touching the registers again;
    // wait on the clock first so the final point has been predicted
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (angles_pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    initial begin
        int len;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // run 0: reset values, field extremes, origin and stand pose, then raw noise
        set_regs(1638, 1638, 2458, 2621, -32768, 32767, -32768, 32767);
        send_point(32767, 32767);
        send_point(-32768, -32768);
        send_point(0, 0);
        send_point(32767, -32768);
        send_point(-32768, 32767);
        send_point(0, -2458);
        send_point(1, -1);
        send_point(-1, 0);
        send_random_path(8);
        drain();

        // run 1: reachable path with tight limits, both range failures show up
        set_regs(1638, 1638, 2458, 2621, -3000, 3000, -9000, -2000);
        send_point(0, 0);
        send_point(0, -3276);
        for (int i = 2; i < NUM_POINTS; i++)
            send_point($urandom_range(0, 4586) - 2293, $urandom_range(0, 4586) - 2293);
        drain();

        // run 2: zero thigh length, every point unreachable, largest hip height
        set_regs(0, 32767, 32767, -32768, -32768, 32767, -32768, 32767);
        send_random_path(0);
        drain();

        // run 3: no idling, long links, inverted hip window and hip saturation
        calm = 1'b1;
        set_regs(16383, 16383, 0, 32767, 100, -100, -32768, 32767);
        send_reachable_path(16383);
        drain();
        calm = 1'b0;

        // run 4: random link length, inverted knee window
        len = $urandom_range(500, 32767);
        set_regs(len, len, $urandom_range(0, 32767), int'($signed(16'($urandom))),
                 -32768, 32767, 0, -1);
        send_reachable_path(len);
        drain();

        repeat (200) @(posedge aclk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // watchdog
    initial begin
        #8ms;
        $display("Regression FAIL");
        $finish;
    end

endmodule
